/* src/tri_area_pkg.sv */
// ----------------------------------------------------------------------------
// tri_area_pkg
// Shared types and codes for the triangle area block.
// ----------------------------------------------------------------------------
package tri_area_pkg;

   // Port widths fixed by the interface
   localparam int SIDE_PORT_WIDTH = 12;
   localparam int AREA_WIDTH      = 25;
   localparam int KIND_WIDTH      = 2;

   // Triangle classes
   localparam logic [KIND_WIDTH-1:0] KIND_EQUI = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_ISO  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_SCAL = 2'd2;

   // Control that travels beside the datapath of one item
   typedef struct packed {
      logic                  strobe;
      logic                  valid_res;
      logic [KIND_WIDTH-1:0] kind;
   } tri_area_tag_type;

endpackage

/* src/triangle_area_from_sides_top.sv */
// ----------------------------------------------------------------------------
// triangle_area_from_sides_top
// Heron triangle area: validity, class and floor(4 * area) from three sides.
// ----------------------------------------------------------------------------
// Usage: pulse start with the three sides on req_side_a/b/c; busy is low
// except during reset, so a new triangle may be issued every clock. Each item
// comes back as a one-cycle rsp_valid strobe, in issue order, after passing
// through three product stages (side sums, two partial products, full
// product) and then a chain of square-root cells, one cell per root bit.
// The receiver cannot stall: capture the rsp_ ports whenever rsp_valid is
// high. Side bits above SIDE_WIDTH are ignored. An invalid triangle (a zero
// side, or one side longer than the other two together) returns
// rsp_valid_res = 0 with kind and area both zero; a degenerate triangle is
// valid with area zero.
// ----------------------------------------------------------------------------
module triangle_area_from_sides_top #(
   parameter int SIDE_WIDTH = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [tri_area_pkg::SIDE_PORT_WIDTH-1:0] req_side_a,
   input  logic [tri_area_pkg::SIDE_PORT_WIDTH-1:0] req_side_b,
   input  logic [tri_area_pkg::SIDE_PORT_WIDTH-1:0] req_side_c,
   output logic                                     rsp_valid,
   output logic                                     rsp_valid_res,
   output logic [tri_area_pkg::KIND_WIDTH-1:0]      rsp_kind,
   output logic [tri_area_pkg::AREA_WIDTH-1:0]      rsp_area_x4
);
   import tri_area_pkg::*;

   localparam int PROD_WIDTH = 4 * SIDE_WIDTH + 2;
   localparam int ROOT_WIDTH = 2 * SIDE_WIDTH + 1;
   localparam int LATENCY    = 3 + ROOT_WIDTH;

   tri_area_tag_type      tag_chain  [0:ROOT_WIDTH];
   logic [PROD_WIDTH-1:0] rad_chain  [0:ROOT_WIDTH];
   logic [ROOT_WIDTH:0]   rem_chain  [0:ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_chain [0:ROOT_WIDTH];
   tri_area_tag_type      last_tag;

   // Hold off new items only while reset clears the pipeline
   assign busy = reset;

   tri_area_front #(
      .SIDE_WIDTH (SIDE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (start & ~busy),
      .up_side_a (req_side_a),
      .up_side_b (req_side_b),
      .up_side_c (req_side_c),
      .dn_tag    (tag_chain[0]),
      .dn_prod   (rad_chain[0])
   );

   // Square root starts from an empty remainder and root
   assign rem_chain[0]  = '0;
   assign root_chain[0] = '0;

   // Advance one root bit per cell
   for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_cell
      tri_area_cell #(
         .RAD_WIDTH  (PROD_WIDTH),
         .ROOT_WIDTH (ROOT_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_tag  (tag_chain[i]),
         .up_rad  (rad_chain[i]),
         .up_rem  (rem_chain[i]),
         .up_root (root_chain[i]),
         .dn_tag  (tag_chain[i+1]),
         .dn_rad  (rad_chain[i+1]),
         .dn_rem  (rem_chain[i+1]),
         .dn_root (root_chain[i+1])
      );
   end

   assign last_tag      = tag_chain[ROOT_WIDTH];
   assign rsp_valid     = last_tag.strobe;
   assign rsp_valid_res = last_tag.valid_res;
   assign rsp_kind      = last_tag.kind;
   assign rsp_area_x4   = AREA_WIDTH'(root_chain[ROOT_WIDTH]);

   // Every accepted item comes out after the fixed pipeline depth
   a_accept_returns : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted item did not return after pipeline depth");

   // No strobe without an item issued at the matching cycle
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_valid)
      else $error("result strobe without an accepted item");

   // Invalid triangles report zero class and zero area
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_kind == KIND_EQUI && rsp_area_x4 == '0))
      else $error("invalid triangle with nonzero class or area");

   // Final remainder never exceeds twice the root
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rem_chain[ROOT_WIDTH]} <=
                     {root_chain[ROOT_WIDTH], 1'b0} + (ROOT_WIDTH+2)'(0)))
      else $error("square root remainder out of range");

endmodule

/* src/tri_area_front.sv */
// ----------------------------------------------------------------------------
// tri_area_front
// Checks and classifies the sides, then forms the Heron product in three
// registered stages.
// ----------------------------------------------------------------------------
module tri_area_front #(
   parameter int SIDE_WIDTH = 12
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      take,
   input  logic [tri_area_pkg::SIDE_PORT_WIDTH-1:0]  up_side_a,
   input  logic [tri_area_pkg::SIDE_PORT_WIDTH-1:0]  up_side_b,
   input  logic [tri_area_pkg::SIDE_PORT_WIDTH-1:0]  up_side_c,
   output tri_area_pkg::tri_area_tag_type            dn_tag,
   output logic [4*SIDE_WIDTH+1:0]                   dn_prod
);
   import tri_area_pkg::*;

   localparam int SUM_WIDTH  = SIDE_WIDTH + 2;
   localparam int DIFF_WIDTH = SIDE_WIDTH + 1;
   localparam int P1_WIDTH   = SUM_WIDTH + DIFF_WIDTH;
   localparam int P2_WIDTH   = 2 * DIFF_WIDTH;
   localparam int FULL_WIDTH = P1_WIDTH + P2_WIDTH;
   localparam int PROD_WIDTH = 4 * SIDE_WIDTH + 2;

   logic [SIDE_WIDTH-1:0] a, b, c;
   logic [DIFF_WIDTH-1:0] sum_bc, sum_ac, sum_ab;
   logic                  bad;
   logic [FULL_WIDTH-1:0] full;

   tri_area_tag_type      tag1_ff, tag1_in, tag2_ff, tag3_ff;
   logic [SUM_WIDTH-1:0]  s_ff, s_in;
   logic [DIFF_WIDTH-1:0] da_ff, da_in, db_ff, db_in, dc_ff, dc_in;
   logic [P1_WIDTH-1:0]   p1_ff, p1_in;
   logic [P2_WIDTH-1:0]   p2_ff, p2_in;
   logic [PROD_WIDTH-1:0] prod_ff, prod_in;

   // Drop side bits above the configured width
   assign a = up_side_a[SIDE_WIDTH-1:0];
   assign b = up_side_b[SIDE_WIDTH-1:0];
   assign c = up_side_c[SIDE_WIDTH-1:0];

   assign sum_bc = {1'b0, b} + {1'b0, c};
   assign sum_ac = {1'b0, a} + {1'b0, c};
   assign sum_ab = {1'b0, a} + {1'b0, b};

   assign bad = (a == '0) || (b == '0) || (c == '0) ||
                ({1'b0, a} > sum_bc) || ({1'b0, b} > sum_ac) || ({1'b0, c} > sum_ab);

   always_comb begin
      tag1_in.strobe    = take;
      tag1_in.valid_res = ~bad;
      if (bad) begin
         tag1_in.kind = KIND_EQUI;
         s_in         = '0;
         da_in        = '0;
         db_in        = '0;
         dc_in        = '0;
      end else begin
         if ((a == b) && (a == c)) begin
            tag1_in.kind = KIND_EQUI;
         end else if ((a == b) || (a == c) || (b == c)) begin
            tag1_in.kind = KIND_ISO;
         end else begin
            tag1_in.kind = KIND_SCAL;
         end
         s_in  = {1'b0, sum_bc} + {2'b00, a};
         da_in = sum_bc - {1'b0, a};
         db_in = sum_ac - {1'b0, b};
         dc_in = sum_ab - {1'b0, c};
      end
   end

   assign p1_in   = s_ff * da_ff;
   assign p2_in   = db_ff * dc_ff;
   assign full    = p1_ff * p2_ff;
   // Product stays below 2^(4*SIDE_WIDTH+2); upper bits are always zero
   assign prod_in = full[PROD_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      dc_ff   <= dc_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      prod_ff <= prod_in;
   end

   assign dn_tag  = tag3_ff;
   assign dn_prod = prod_ff;

endmodule

/* src/tri_area_cell.sv */
// ----------------------------------------------------------------------------
// tri_area_cell
// One step of the digit-by-digit square root: settles one root bit and
// hands radicand, remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module tri_area_cell #(
   parameter int RAD_WIDTH  = 50,
   parameter int ROOT_WIDTH = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tri_area_pkg::tri_area_tag_type up_tag,
   input  logic [RAD_WIDTH-1:0]           up_rad,
   input  logic [ROOT_WIDTH:0]            up_rem,
   input  logic [ROOT_WIDTH-1:0]          up_root,
   output tri_area_pkg::tri_area_tag_type dn_tag,
   output logic [RAD_WIDTH-1:0]           dn_rad,
   output logic [ROOT_WIDTH:0]            dn_rem,
   output logic [ROOT_WIDTH-1:0]          dn_root
);
   import tri_area_pkg::*;

   localparam int TRY_WIDTH = ROOT_WIDTH + 3;

   logic [TRY_WIDTH-1:0]  cur, trial, diff;
   logic                  fits;

   tri_area_tag_type      tag_ff;
   logic [RAD_WIDTH-1:0]  rad_ff, rad_in;
   logic [ROOT_WIDTH:0]   rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0] root_ff, root_in;

   // Bring down the next two radicand bits and try root*4+1
   assign cur   = {up_rem, up_rad[RAD_WIDTH-1 -: 2]};
   assign trial = TRY_WIDTH'({up_root, 2'b01});
   assign fits  = (cur >= trial);
   assign diff  = fits ? (cur - trial) : cur;

   assign rem_in  = diff[ROOT_WIDTH:0];
   assign root_in = {up_root[ROOT_WIDTH-2:0], fits};
   assign rad_in  = {up_rad[RAD_WIDTH-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= up_tag;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign dn_tag  = tag_ff;
   assign dn_rad  = rad_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;

endmodule

/* tb/triangle_area_from_sides_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_area_from_sides_top_tb
// Self-checking bench for the Heron triangle area block.
// A queue of triangles feeds a clocked driver with random gaps between items.
// A clocked monitor predicts validity, class and floor(4 * area) for every
// accepted item. It checks each rsp_valid strobe in order against that
// prediction.
// ----------------------------------------------------------------------------
module triangle_area_from_sides_top_tb;

   import tri_area_pkg::*;

   localparam int          SIDE_W      = 12;
   localparam int          LATENCY     = 3 + 2 * SIDE_W + 1;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          RESET_CYCLES = 11;
   localparam int          RANDOM_ITEMS = 1500;
   localparam int          MAX_SIDE    = (1 << SIDE_PORT_WIDTH) - 1;
   localparam logic [63:0] SIDE_MASK   = (64'd1 << SIDE_W) - 64'd1;

   typedef logic [SIDE_PORT_WIDTH-1:0] side_type;

   // One triangle to issue, with the idle cycles to leave ahead of it
   typedef struct {
      side_type    a;
      side_type    b;
      side_type    c;
      int unsigned gap;
      bit          drain;   // hold off until every earlier result is back
   } triangle_item_type;

   // Predicted result, with the sides kept for messages
   typedef struct {
      side_type              a;
      side_type              b;
      side_type              c;
      logic                  valid_res;
      logic [KIND_WIDTH-1:0] kind;
      logic [AREA_WIDTH-1:0] area_x4;
   } area_result_type;

   // Shapes that the random part draws from
   typedef enum {
      SHAPE_GENERAL, SHAPE_SMALL, SHAPE_ISO, SHAPE_DEGEN, SHAPE_OVER, SHAPE_NOISE
   } shape_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   side_type              req_side_a = '0;
   side_type              req_side_b = '0;
   side_type              req_side_c = '0;
   logic                  rsp_valid;
   logic                  rsp_valid_res;
   logic [KIND_WIDTH-1:0] rsp_kind;
   logic [AREA_WIDTH-1:0] rsp_area_x4;

   triangle_item_type pending_items[$];
   area_result_type   area_results_due[$];

   triangle_item_type cur_item;
   bit                item_loaded = 1'b0;
   int unsigned       hold_cycles = 0;

   int unsigned n_accepted = 0;
   int unsigned n_results  = 0;
   int unsigned cycle_count = 0;
   int unsigned errors     = 0;
   int unsigned n_invalid = 0, n_degen = 0, n_equi = 0, n_iso = 0, n_scal = 0;

   triangle_area_from_sides_top #(
      .SIDE_WIDTH(SIDE_W)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_side_a   (req_side_a),
      .req_side_b   (req_side_b),
      .req_side_c   (req_side_c),
      .rsp_valid    (rsp_valid),
      .rsp_valid_res(rsp_valid_res),
      .rsp_kind     (rsp_kind),
      .rsp_area_x4  (rsp_area_x4)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predict one result: validity check, class, then the exact integer
   // square root of the Heron product (a+b+c)(b+c-a)(a+c-b)(a+b-c).
   function automatic area_result_type heron_area(input side_type a_in,
                                                  input side_type b_in,
                                                  input side_type c_in);
      logic [63:0]     a, b, c, prod, root, trial;
      area_result_type r;
      int              bit_idx;
      a = 64'(a_in) & SIDE_MASK;
      b = 64'(b_in) & SIDE_MASK;
      c = 64'(c_in) & SIDE_MASK;
      r.a         = a_in;
      r.b         = b_in;
      r.c         = c_in;
      // an invalid triangle returns every field cleared
      r.valid_res = 1'b0;
      r.kind      = KIND_EQUI;
      r.area_x4   = '0;
      if (a == 0 || b == 0 || c == 0 || a > b + c || b > a + c || c > a + b)
         return r;
      r.valid_res = 1'b1;
      if (a == b && b == c)
         r.kind = KIND_EQUI;
      else if (a == b || a == c || b == c)
         r.kind = KIND_ISO;
      else
         r.kind = KIND_SCAL;
      prod = (a + b + c) * (b + c - a) * (a + c - b) * (a + b - c);
      // build the root one bit at a time from the top; the product is below 2^50
      root = '0;
      for (bit_idx = AREA_WIDTH; bit_idx >= 0; bit_idx--) begin
         trial = root | (64'd1 << bit_idx);
         if (trial * trial <= prod)
            root = trial;
      end
      r.area_x4 = root[AREA_WIDTH-1:0];
      return r;
   endfunction

   task automatic add_item(input int unsigned a, input int unsigned b, input int unsigned c,
                           input int unsigned gap, input bit drain);
      triangle_item_type it;
      it.a     = side_type'(a);
      it.b     = side_type'(b);
      it.c     = side_type'(c);
      it.gap   = gap;
      it.drain = drain;
      pending_items.push_back(it);
   endtask

   // Driver: at each rising edge decide what start and the sides carry for the
   // next cycle. An item held on start stays there until busy is low; after an
   // accept the next item follows at once when its gap is zero, so start is
   // never dropped and raised within one step.
   always @(posedge clock) begin : drive_proc
      logic accepted;
      int   in_flight;
      if (reset) begin
         start <= 1'b0;
      end else begin
         accepted  = start && !busy;
         // counters are the values before this edge; add what this edge moves
         in_flight = int'(n_accepted) - int'(n_results) + (accepted ? 1 : 0)
                     - (rsp_valid ? 1 : 0);
         if (start && !accepted) begin
            // hold the item until the block takes it
         end else begin
            if (!item_loaded && pending_items.size() != 0) begin
               cur_item    = pending_items.pop_front();
               hold_cycles = cur_item.gap;
               item_loaded = 1'b1;
            end
            if (item_loaded && hold_cycles == 0 && !(cur_item.drain && in_flight != 0)) begin
               start       <= 1'b1;
               req_side_a  <= cur_item.a;
               req_side_b  <= cur_item.b;
               req_side_c  <= cur_item.c;
               item_loaded = 1'b0;
            end else begin
               start <= 1'b0;
               if (item_loaded && hold_cycles != 0)
                  hold_cycles--;
            end
         end
      end
   end

   // Monitor: check the result strobed in the cycle ending at this edge against
   // the oldest prediction, then record a prediction for the item accepted here.
   always @(posedge clock) begin : check_proc
      area_result_type due;
      if (!reset) begin
         if (rsp_valid) begin
            n_results <= n_results + 1;
            if (area_results_due.size() == 0) begin
               $display("%0t: result with nothing outstanding: valid_res %0d kind %0d area_x4 %0d",
                        $time, rsp_valid_res, rsp_kind, rsp_area_x4);
               errors++;
            end else begin
               due = area_results_due.pop_front();
               if (rsp_valid_res !== due.valid_res) begin
                  $display("%0t: valid_res for sides (%0d,%0d,%0d): expected %0d, actual %0d",
                           $time, due.a, due.b, due.c, due.valid_res, rsp_valid_res);
                  errors++;
               end
               if (rsp_kind !== due.kind) begin
                  $display("%0t: kind for sides (%0d,%0d,%0d): expected %0d, actual %0d",
                           $time, due.a, due.b, due.c, due.kind, rsp_kind);
                  errors++;
               end
               if (rsp_area_x4 !== due.area_x4) begin
                  $display("%0t: area_x4 for sides (%0d,%0d,%0d): expected %0d, actual %0d",
                           $time, due.a, due.b, due.c, due.area_x4, rsp_area_x4);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            n_accepted <= n_accepted + 1;
            due = heron_area(req_side_a, req_side_b, req_side_c);
            area_results_due.push_back(due);
            // tally what the run reaches
            if (!due.valid_res)
               n_invalid++;
            else if (due.area_x4 == 0)
               n_degen++;
            if (due.valid_res && due.kind == KIND_EQUI)
               n_equi++;
            if (due.valid_res && due.kind == KIND_ISO)
               n_iso++;
            if (due.valid_res && due.kind == KIND_SCAL)
               n_scal++;
         end
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, area_results_due.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int unsigned a, b, c, lo, hi, sw, gap;
      int          n, burst_left;
      bit          bursty;
      shape_type   shape;

      // Directed part: zero sides, the smallest and largest triangles, each class,
      // degenerate ones, and zero sides and sides just too long in every position.
      add_item(0, 0, 0, 0, 0);
      add_item(0, 5, 5, 0, 0);
      add_item(5, 0, 5, 1, 0);
      add_item(5, 5, 0, 0, 0);
      add_item(1, 1, 1, 3, 0);
      add_item(MAX_SIDE, MAX_SIDE, MAX_SIDE, 0, 0);
      add_item(1, 1, 2, 0, 0);
      add_item(1, 2, 3, 2, 0);
      add_item(2048, 2047, MAX_SIDE, 0, 0);
      add_item(1, 2, 4, 0, 0);
      add_item(4, 1, 2, 0, 0);
      add_item(1, 4, 2, 10, 0);
      add_item(3, 4, 5, 0, 1);
      add_item(5, 3, 4, 0, 0);
      add_item(MAX_SIDE, 1, MAX_SIDE, 0, 0);
      add_item(1, MAX_SIDE, MAX_SIDE, 4, 0);
      add_item(MAX_SIDE, MAX_SIDE, 1, 0, 0);
      add_item(MAX_SIDE, MAX_SIDE - 1, MAX_SIDE - 2, 0, 0);
      add_item(MAX_SIDE, 2048, 2048, 7, 0);
      add_item(MAX_SIDE, 2047, 2047, 0, 0);
      add_item(2047, MAX_SIDE, 2047, 0, 0);
      add_item(MAX_SIDE, 0, MAX_SIDE, 0, 0);
      add_item('hAAA, 'h555, 'hFFF, 0, 0);
      add_item('h555, 'hAAA, 'h800, 0, 0);

      // Random part: mostly real triangles, with noise and near misses mixed in.
      // Each run of items is either back-to-back or has random gaps.
      burst_left = 0;
      bursty     = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(10, 60);
            bursty     = ($urandom_range(0, 2) == 0);
         end
         burst_left--;
         gap = bursty ? 0 : $urandom_range(0, 10);
         sw  = $urandom_range(0, 9);
         shape = (sw < 4) ? SHAPE_GENERAL :
                 (sw == 4) ? SHAPE_SMALL :
                 (sw == 5 || sw == 6) ? SHAPE_ISO :
                 (sw == 7) ? SHAPE_DEGEN :
                 (sw == 8) ? SHAPE_OVER : SHAPE_NOISE;
         case (shape)
            SHAPE_GENERAL: begin
               a  = $urandom_range(1, MAX_SIDE);
               b  = $urandom_range(1, MAX_SIDE);
               lo = (a > b) ? a - b : b - a;
               if (lo == 0)
                  lo = 1;
               hi = (a + b > MAX_SIDE) ? MAX_SIDE : a + b;
               c  = $urandom_range(lo, hi);
            end
            SHAPE_SMALL: begin
               a = $urandom_range(1, 15);
               b = $urandom_range(1, 15);
               c = $urandom_range(1, 15);
            end
            SHAPE_ISO: begin
               a  = $urandom_range(1, MAX_SIDE);
               b  = a;
               hi = (2 * a > MAX_SIDE) ? MAX_SIDE : 2 * a;
               c  = ($urandom_range(0, 3) == 0) ? a : $urandom_range(1, hi);
            end
            SHAPE_DEGEN: begin
               a = $urandom_range(1, MAX_SIDE - 1);
               b = $urandom_range(1, MAX_SIDE - a);
               c = a + b;
            end
            SHAPE_OVER: begin
               // one side a unit too long, or a zero side
               a = $urandom_range(1, MAX_SIDE - 2);
               b = $urandom_range(1, MAX_SIDE - 1 - a);
               c = a + b + 1;
               if ($urandom_range(0, 3) == 0)
                  a = 0;
            end
            default: begin
               a = $urandom_range(0, MAX_SIDE);
               b = $urandom_range(0, MAX_SIDE);
               c = $urandom_range(0, MAX_SIDE);
            end
         endcase
         // shuffle which port gets which side
         if ($urandom_range(0, 1)) begin
            sw = a; a = b; b = sw;
         end
         if ($urandom_range(0, 1)) begin
            sw = b; b = c; c = sw;
         end
         if ($urandom_range(0, 1)) begin
            sw = a; a = c; c = sw;
         end
         add_item(a, b, c, gap, (n == 0) || ($urandom_range(0, 199) == 0));
      end

      // Release reset after the fixed hold
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Advance until every item is issued and every result is back
      do
         @(negedge clock);
      while (pending_items.size() != 0 || item_loaded || start || n_accepted != n_results);

      // Allow the pipeline to drain for stray results
      repeat (LATENCY + 20) @(negedge clock);

      if (area_results_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, area_results_due.size());
         errors += area_results_due.size();
      end

      $display("Run covered %0d triangles (%0d results): %0d equilateral, %0d isosceles,",
               n_accepted, n_results, n_equi, n_iso);
      $display("  %0d scalene, %0d degenerate, %0d invalid; %0d field mismatches",
               n_scal, n_degen, n_invalid, errors);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
